// File: sv/tgr_pkg.sv
// ============================================================================
// tgr_pkg: shared types, constants and font table of the text glyph renderer
// Holds the 5x7 column font, the entry type that the front end passes to the
// pixel sequencer, and the screen grid constants.
// ============================================================================
package tgr_pkg;

    localparam int GLYPH_W     = 5;
    localparam int GLYPH_H     = 7;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] FIRST_CODE = 8'd32;
    localparam logic [7:0] LAST_CODE  = 8'd127;
    localparam logic [5:0] LAST_COL   = 6'd20;
    localparam logic [5:0] LAST_ROW   = 6'd19;

    localparam logic [2:0] LAST_GLYPH_COL = 3'(GLYPH_W - 1);
    localparam logic [2:0] LAST_GLYPH_ROW = 3'(GLYPH_H - 1);

    // Input mode codes.
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_SET   = 1'b1;

    // One glyph: five columns of seven pixel rows, bit r is row r.
    typedef logic [GLYPH_W-1:0][GLYPH_H-1:0] t_glyph;

    // Work handed from the front end to the pixel sequencer.
    typedef struct packed {
        logic [7:0]  x0;
        logic [7:0]  y0;
        t_glyph      glyph;
        logic [15:0] fg;
    } t_entry;

    // Font rows, column 0 in the top byte.
    localparam logic [39:0] FONT_TABLE [96] = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
        40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
        40'h001C224100, 40'h0041221C00, 40'h082A1C2A08, 40'h08083E0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
        40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
        40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
        40'h0008142241, 40'h1414141414, 40'h4122140800, 40'h0201510906,
        40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141221C, 40'h7F49494941, 40'h7F09090101, 40'h3E41415132,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
        40'h7F40404040, 40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
        40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
        40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F,
        40'h6314081463, 40'h0304780403, 40'h6151494543, 40'h00007F4141,
        40'h0204081020, 40'h41417F0000, 40'h0402010204, 40'h4040404040,
        40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
        40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h081454543C,
        40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h007F102844,
        40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
        40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
        40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
        40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
        40'h00007F0000, 40'h0041360800, 40'h08082A1C08, 40'h081C2A0808
    };

    // Glyph of a character code; codes without a glyph come back blank.
    function automatic t_glyph glyph_lookup(input logic [7:0] code);
        t_glyph      g;
        logic [6:0]  idx;
        logic [39:0] row_bits;
        g        = '0;
        idx      = 7'(code - FIRST_CODE);
        row_bits = FONT_TABLE[idx];
        if (code >= FIRST_CODE && code <= LAST_CODE) begin
            for (int c = 0; c < GLYPH_W; c++) begin
                g[c] = row_bits[8*(GLYPH_W-1-c) +: GLYPH_H];
            end
        end
        return g;
    endfunction

endpackage

// File: sv/tgr_front.sv
// ============================================================================
// tgr_front: input stage of the text glyph renderer
// Keeps the cursor, loads it in set mode and, in write mode, looks up the
// glyph and pushes one entry per character into the queue.
// ============================================================================
module tgr_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic            i_mode,
    input  logic [7:0]      i_char_code,
    input  logic [15:0]     i_glyph_color,
    input  logic [4:0]      i_new_col,
    input  logic [4:0]      i_new_row,
    output logic            o_push,
    output tgr_pkg::t_entry o_entry
);
    import tgr_pkg::*;

    logic [4:0] r_col;
    logic [4:0] r_row;
    logic [4:0] n_col;
    logic [4:0] n_row;
    logic [5:0] adv_col;
    logic [5:0] adv_row;

    // Cursor advance, done in six bits so a column of 31 still wraps to 1.
    always_comb begin
        adv_col = {1'b0, r_col} + 6'd1;
        adv_row = {1'b0, r_row};
        if (adv_col > LAST_COL) begin
            adv_col = 6'd1;
            adv_row = {1'b0, r_row} + 6'd1;
        end
        if (adv_row > LAST_ROW) begin
            adv_row = 6'd1;
        end
        n_col = adv_col[4:0];
        n_row = adv_row[4:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_accept) begin
            if (i_mode == MODE_SET) begin
                r_col <= i_new_col;
                r_row <= i_new_row;
            end else begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    assign o_push        = i_accept && (i_mode == MODE_WRITE);
    assign o_entry.x0    = {1'b0, r_col, 2'b00} + {2'b00, r_col, 1'b0};
    assign o_entry.y0    = {r_row, 3'b000};
    assign o_entry.glyph = glyph_lookup(i_char_code);
    assign o_entry.fg    = i_glyph_color;

endmodule

// File: sv/tgr_queue.sv
// ============================================================================
// tgr_queue: character queue between front end and pixel sequencer
// A small first-in first-out buffer of glyph entries.
// ============================================================================
module tgr_queue #(
    parameter int DEPTH = tgr_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tgr_pkg::t_entry i_entry,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output tgr_pkg::t_entry o_head
);
    import tgr_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [IDX_W-1:0]   r_wr_ptr;
    logic [IDX_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    function automatic logic [IDX_W-1:0] ptr_next(input logic [IDX_W-1:0] p);
        return (p == IDX_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_next(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

endmodule

// File: sv/tgr_back.sv
// ============================================================================
// tgr_back: pixel sequencer of the text glyph renderer
// Walks one glyph in row-major order and drives one pixel word per cycle,
// while the output is not stalled, through an output register.
// ============================================================================
module tgr_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [15:0]     i_bg_color,
    input  logic            i_empty,
    input  tgr_pkg::t_entry i_head,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic [7:0]      o_pixel_x,
    output logic [7:0]      o_pixel_y,
    output logic [15:0]     o_pixel_color,
    output logic            o_last_pixel
);
    import tgr_pkg::*;

    t_entry      r_ent;
    logic        r_busy;
    logic [2:0]  r_gcol;
    logic [2:0]  r_grow;
    logic        r_out_valid;
    logic [7:0]  r_px;
    logic [7:0]  r_py;
    logic [15:0] r_pcolor;
    logic        r_plast;
    logic        out_load;
    logic        at_last;

    assign out_load = r_busy && (!r_out_valid || !i_out_stall);
    assign at_last  = (r_gcol == LAST_GLYPH_COL) && (r_grow == LAST_GLYPH_ROW);
    assign o_pop    = !i_empty && (!r_busy || (out_load && at_last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_gcol      <= '0;
            r_grow      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_gcol <= '0;
                r_grow <= '0;
            end else if (out_load) begin
                if (at_last) begin
                    r_busy <= 1'b0;
                end else if (r_gcol == LAST_GLYPH_COL) begin
                    r_gcol <= '0;
                    r_grow <= r_grow + 3'd1;
                end else begin
                    r_gcol <= r_gcol + 3'd1;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ent <= i_head;
        end
        if (out_load) begin
            r_px     <= r_ent.x0 + {5'd0, r_gcol};
            r_py     <= r_ent.y0 + {5'd0, r_grow};
            r_pcolor <= r_ent.glyph[r_gcol][r_grow] ? r_ent.fg : i_bg_color;
            r_plast  <= at_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_x     = r_px;
    assign o_pixel_y     = r_py;
    assign o_pixel_color = r_pcolor;
    assign o_last_pixel  = r_plast;

endmodule

// File: sv/text_glyph_renderer_unit.sv
// ============================================================================
// text_glyph_renderer_unit: text-mode character generator with a cursor
// Renders 5x7 glyphs from a built-in font as a stream of pixel words.
// ============================================================================
// A write-mode word (mode 0) renders one character at the cursor and yields
// 35 pixel words, row by row and five columns to a row, the last one flagged
// by last_pixel; the cursor then advances, wrapping past column 20 to column 1
// of the next row and past row 19 back to row 1. A set-mode word (mode 1)
// loads the cursor and yields nothing. Codes outside 32..127 draw a blank
// cell in the background color, which is to be written through the
// configuration port only while the block is idle; the block does not
// enforce this. The pixel sequencer that walks the glyph yields one pixel
// word per cycle while the output is not stalled. The front end takes new
// words while the sequencer is busy, as long as the character queue has
// room, so the output runs back to back across characters. The pixel
// output is registered and a stall holds it unchanged.
module text_glyph_renderer_unit #(
    parameter int QUEUE_DEPTH = tgr_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_mode,
    input  logic [7:0]  i_char_code,
    input  logic [15:0] i_glyph_color,
    input  logic [4:0]  i_new_col,
    input  logic [4:0]  i_new_row,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_pixel_x,
    output logic [7:0]  o_pixel_y,
    output logic [15:0] o_pixel_color,
    output logic        o_last_pixel
);
    import tgr_pkg::*;

    logic [15:0] r_bg_color;
    logic        in_accept;
    logic        push;
    logic        pop;
    logic        q_full;
    logic        q_empty;
    t_entry      push_entry;
    t_entry      head_entry;

    // Background color register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bg_color <= '0;
        end else if (i_cfg_wr_en) begin
            r_bg_color <= i_cfg_wr_data;
        end
    end

    // The input stalls only when the queue is full; set-mode words wait too,
    // which keeps cursor loads in order with the characters ahead of them.
    assign o_in_stall = q_full;
    assign in_accept  = i_in_valid && !o_in_stall;

    tgr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_mode        (i_mode),
        .i_char_code   (i_char_code),
        .i_glyph_color (i_glyph_color),
        .i_new_col     (i_new_col),
        .i_new_row     (i_new_row),
        .o_push        (push),
        .o_entry       (push_entry)
    );

    tgr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head_entry)
    );

    tgr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_bg_color    (r_bg_color),
        .i_empty       (q_empty),
        .i_head        (head_entry),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_pixel_color (o_pixel_color),
        .o_last_pixel  (o_last_pixel)
    );

endmodule

// File: sv/tgr_checker.sv
// ============================================================================
// tgr_checker: port checks of the text glyph renderer
// Watches the top-level ports and flags output behavior that cannot occur.
// ============================================================================
module tgr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [7:0]  o_pixel_x,
    input logic [7:0]  o_pixel_y,
    input logic [15:0] o_pixel_color,
    input logic        o_last_pixel
);

    // A stalled pixel word stays valid and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_pixel_x)
            && $stable(o_pixel_y) && $stable(o_pixel_color) && $stable(o_last_pixel))
        else $error("stalled pixel word changed");

    // Reset empties the output.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("pixel word valid right after reset");

    // The flagged pixel sits on glyph row six of its cell.
    a_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last_pixel |-> o_pixel_y[2:0] == 3'd6)
        else $error("last pixel not on the bottom glyph row");

    // The spacing row of a cell is never drawn.
    a_no_gap_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_pixel_y[2:0] != 3'd7)
        else $error("pixel drawn in the cell spacing row");

endmodule

bind text_glyph_renderer_unit tgr_checker u_tgr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_pixel_x     (o_pixel_x),
    .o_pixel_y     (o_pixel_y),
    .o_pixel_color (o_pixel_color),
    .o_last_pixel  (o_last_pixel)
);
